>>> rtl/dpp_pkg.sv
// ----------------------------------------------------------------------------
// dpp_pkg
// Types, constants and helpers shared by the decimal pair parser.
// ----------------------------------------------------------------------------
package dpp_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int OUT_WIDTH   = 16;
  localparam int CHAR_WIDTH  = 8;
  localparam int SKIP_WIDTH  = 8;

  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_WIDTH-1:0] CHAR_COMMA = 8'h2c;

  typedef enum logic [7:0] {
    PH_IDLE = 8'b0000_0001,
    PH_SKIP = 8'b0000_0010,
    PH_F0   = 8'b0000_0100,
    PH_F1   = 8'b0000_1000,
    PH_S0   = 8'b0001_0000,
    PH_S1   = 8'b0010_0000,
    PH_DONE = 8'b0100_0000,
    PH_FAIL = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    phase_t                  phase;
    logic [SKIP_WIDTH-1:0]   skip_left;
    logic [VALUE_WIDTH-1:0]  first_acc;
    logic [VALUE_WIDTH-1:0]  second_acc;
    logic                    wrap_seen;
  } state_t;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] first_value;
    logic [OUT_WIDTH-1:0] second_value;
    logic                 ok;
    logic                 wrapped;
  } result_t;

  typedef struct packed {
    logic                   wrap;
    logic [VALUE_WIDTH-1:0] value;
  } mac_t;

  localparam state_t STATE_CLEAR = '{
    phase:      PH_IDLE,
    skip_left:  '0,
    first_acc:  '0,
    second_acc: '0,
    wrap_seen:  1'b0
  };

  // acc * 10 + digit, with a flag when the true sum leaves VALUE_WIDTH bits
  function automatic mac_t mac10(input logic [VALUE_WIDTH-1:0] acc,
                                 input logic [3:0] digit);
    logic [VALUE_WIDTH+3:0] wide;
    logic [VALUE_WIDTH+3:0] sum;
    mac_t                   res;
    wide      = {4'b0000, acc};
    sum       = (wide << 3) + (wide << 1) + {{VALUE_WIDTH{1'b0}}, digit};
    res.value = sum[VALUE_WIDTH-1:0];
    res.wrap  = |sum[VALUE_WIDTH+3:VALUE_WIDTH];
    return res;
  endfunction

endpackage

>>> rtl/dpp_if.sv
// ----------------------------------------------------------------------------
// dpp_in_if / dpp_out_if
// Valid/ready channels for characters in and parse results out.
// ----------------------------------------------------------------------------
interface dpp_in_if;
  import dpp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CHAR_WIDTH-1:0] char_in;
  logic                  last;
  modport source (output valid, output char_in, output last, input ready);
  modport sink   (input valid, input char_in, input last, output ready);
endinterface

interface dpp_out_if;
  import dpp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OUT_WIDTH-1:0] first_value;
  logic [OUT_WIDTH-1:0] second_value;
  logic                 ok;
  logic                 wrapped;
  modport source (output valid, output first_value, output second_value,
                  output ok, output wrapped, input ready);
  modport sink   (input valid, input first_value, input second_value,
                  input ok, input wrapped, output ready);
endinterface

>>> rtl/dpp_step.sv
// ----------------------------------------------------------------------------
// dpp_step
// One character of the parse: next state and the message result.
// ----------------------------------------------------------------------------
module dpp_step (
  input  dpp_pkg::state_t                 cur,
  input  logic [dpp_pkg::SKIP_WIDTH-1:0]  skip_count,
  input  logic [dpp_pkg::CHAR_WIDTH-1:0]  char_in,
  input  logic                            last,
  output dpp_pkg::state_t                 nxt,
  output dpp_pkg::result_t                res
);
  import dpp_pkg::*;

  state_t                 st;
  logic                   consumed;
  logic                   is_digit;
  logic [3:0]             digit;
  logic                   use_second;
  logic [VALUE_WIDTH-1:0] acc_sel;
  mac_t                   mac;
  logic                   ok;
  logic [CHAR_WIDTH-1:0]  char_off;

  assign is_digit   = char_in inside {[CHAR_ZERO:CHAR_NINE]};
  assign char_off   = char_in - CHAR_ZERO;
  assign digit      = char_off[3:0];
  assign use_second = (cur.phase == PH_S0) || (cur.phase == PH_S1);
  assign acc_sel    = use_second ? cur.second_acc : cur.first_acc;
  assign mac        = mac10(acc_sel, digit);

  always_comb begin
    st       = cur;
    consumed = 1'b0;

    if (st.phase == PH_IDLE) begin
      st.skip_left = skip_count;
      st.phase     = PH_SKIP;
    end

    if (st.phase == PH_SKIP) begin
      if (st.skip_left != '0) begin
        st.skip_left = st.skip_left - 1'b1;
        consumed     = 1'b1;
      end else begin
        st.phase = PH_F0;
      end
    end

    if (!consumed) begin
      case (st.phase)
        PH_F0: begin
          if (is_digit) begin
            st.first_acc = mac.value;
            st.wrap_seen = st.wrap_seen | mac.wrap;
            st.phase     = PH_F1;
          end else begin
            st.phase = PH_FAIL;
          end
        end
        PH_F1: begin
          if (is_digit) begin
            st.first_acc = mac.value;
            st.wrap_seen = st.wrap_seen | mac.wrap;
          end else if (char_in == CHAR_COMMA) begin
            st.phase = PH_S0;
          end else begin
            st.phase = PH_FAIL;
          end
        end
        PH_S0: begin
          if (is_digit) begin
            st.second_acc = mac.value;
            st.wrap_seen  = st.wrap_seen | mac.wrap;
            st.phase      = PH_S1;
          end else begin
            st.phase = PH_FAIL;
          end
        end
        PH_S1: begin
          if (is_digit) begin
            st.second_acc = mac.value;
            st.wrap_seen  = st.wrap_seen | mac.wrap;
          end else begin
            st.phase = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end

    ok               = (st.phase == PH_S1) || (st.phase == PH_DONE);
    res.ok           = ok;
    res.first_value  = ok ? OUT_WIDTH'(st.first_acc) : '0;
    res.second_value = ok ? OUT_WIDTH'(st.second_acc) : '0;
    res.wrapped      = ok & st.wrap_seen;

    nxt = last ? STATE_CLEAR : st;
  end

endmodule

>>> rtl/decimal_pair_parser.sv
// ----------------------------------------------------------------------------
// decimal_pair_parser
// Parses "digits,digits" from a character stream after a configured skip.
// ----------------------------------------------------------------------------
// a last character's result goes through the input and result registers
// throughput: one character per cycle, also while a result waits to be taken,
// but the parse stage holds the input register only while it carries a last
// character and the result register is still full
// reset (rst_n low, synchronous): both stages empty, parser idle, skip_count 0
// ----------------------------------------------------------------------------
module decimal_pair_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [dpp_pkg::SKIP_WIDTH-1:0] cfg_wr_data,
  dpp_in_if.sink                         in_ch,
  dpp_out_if.source                      out_ch
);
  import dpp_pkg::*;

  // configuration
  logic [SKIP_WIDTH-1:0] skip_count_r;

  // input register stage
  logic                  s1_valid_r;
  logic [CHAR_WIDTH-1:0] s1_char_r;
  logic                  s1_last_r;

  // parse state carried across the characters of a message
  state_t                state_r;
  state_t                state_nxt;

  // result register stage
  logic                  out_valid_r;
  result_t               out_res_r;
  result_t               res_nxt;

  logic                  out_free;
  logic                  s1_fire;
  logic                  in_ready;

  // result slot frees up when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ch.ready;
  // non-last characters never need the result slot
  assign s1_fire  = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready = !s1_valid_r || s1_fire;

  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_count_r <= '0;
    end else if (cfg_wr_en) begin
      skip_count_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_char_r <= in_ch.char_in;
      s1_last_r <= in_ch.last;
    end
  end

  // one character of parse logic
  dpp_step u_step (
    .cur        (state_r),
    .skip_count (skip_count_r),
    .char_in    (s1_char_r),
    .last       (s1_last_r),
    .nxt        (state_nxt),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_CLEAR;
    end else if (s1_fire) begin
      state_r <= state_nxt;
    end
  end

  // result register, loaded only by a last character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.first_value  = out_res_r.first_value;
  assign out_ch.second_value = out_res_r.second_value;
  assign out_ch.ok           = out_res_r.ok;
  assign out_ch.wrapped      = out_res_r.wrapped;

endmodule

>>> rtl/dpp_checker.sv
// ----------------------------------------------------------------------------
// dpp_checker
// Port-level checks on the result channel of the decimal pair parser.
// ----------------------------------------------------------------------------
module dpp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [dpp_pkg::OUT_WIDTH-1:0] out_first_value,
  input logic [dpp_pkg::OUT_WIDTH-1:0] out_second_value,
  input logic                          out_ok,
  input logic                          out_wrapped
);
  import dpp_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_first_value)
      && $stable(out_second_value) && $stable(out_ok) && $stable(out_wrapped))
    else $error("stalled result changed");

  // failed match reports zero values
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_first_value == '0 && out_second_value == '0)
    else $error("failed match with nonzero values");

  // wrap flag only on a match
  a_wrap_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wrapped |-> out_ok)
    else $error("wrapped without ok");

  // reset empties the result stage
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind decimal_pair_parser dpp_checker u_dpp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_first_value  (out_ch.first_value),
  .out_second_value (out_ch.second_value),
  .out_ok           (out_ch.ok),
  .out_wrapped      (out_ch.wrapped)
);
